// ===== hdl/tsms_pkg.sv =====
// types, constants and fixed-point helpers for the two-species slope solver
// no dependencies; used by tsms_div and two_species_micro_slope_solve
`default_nettype none

package tsms_pkg;

  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int DOF_W   = 4;
  localparam int DIV_QW  = Q_W + FRAC_W;
  localparam int CFG_A_W = 1;

  localparam logic [CFG_A_W-1:0] REG_DOF_ONE = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_DOF_TWO = 1'd1;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    q_t   rho1;  q_t rho2;  q_t u;     q_t lam;   q_t w1;    q_t w2;
    q_t   w3;    q_t w4;    q_t uu;    q_t lamsq; q_t sumw;  q_t den;
    q_t   rs;    q_t u2;    q_t lam2;  q_t c1;    q_t c2;    q_t uw;
    q_t   rsu;   q_t rho1u; q_t rho2u; q_t g;     q_t lamsq2; q_t psi1;
    q_t   c1w1;  q_t c2w2;  q_t rho1c1; q_t rho2c2; q_t psi2; q_t u2psi1;
    q_t   t;     q_t num;   q_t p;     q_t hn;    q_t a1;    q_t a2;
    q_t   h;     q_t d;     q_t n;     q_t m1;    q_t m2;    q_t e1;
    q_t   e2;
    logic fault;
  } work_t;

  function automatic q_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? Q_MIN : Q_MAX;
    return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // product rounded to nearest, ties up, then saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] pr;
    logic signed [64:0] r;
    logic signed [48:0] t;
    pr = a * b;
    r  = {pr[63], pr} + 65'sd32768;
    t  = r[64:16];
    if (t > 49'sh0_7fff_ffff) return Q_MAX;
    if (t < -49'sh0_8000_0000) return Q_MIN;
    return t[31:0];
  endfunction

  // small integer (K+1) times a Q16.16 value
  function automatic q_t kmul(input logic [DOF_W:0] k, input q_t a);
    logic signed [37:0] pr;
    pr = $signed({1'b0, k}) * a;
    if (pr > 38'sh0_7fff_ffff) return Q_MAX;
    if (pr < -38'sh0_8000_0000) return Q_MIN;
    return pr[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tsms_div.sv =====
// pipelined signed Q16.16 divider, one quotient bit per stage, with side data
// depends on tsms_pkg
`default_nettype none

module tsms_div
  import tsms_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire q_t                a,
  input  wire q_t                b,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output q_t                     q,
  output logic [SIDE_W-1:0]      side_out
);

  logic              vld_r  [0:DIV_QW];
  logic [DIV_QW-1:0] num_r  [0:DIV_QW];
  logic [Q_W-1:0]    rem_r  [0:DIV_QW];
  logic [Q_W-1:0]    dmag_r [0:DIV_QW];
  logic              neg_r  [0:DIV_QW];
  logic              bz_r   [0:DIV_QW];
  logic [SIDE_W-1:0] side_r [0:DIV_QW];

  logic              out_valid_r;
  q_t                q_r;
  logic [SIDE_W-1:0] side_out_r;

  logic [Q_W-1:0] amag, bmag;
  q_t             q_nxt;
  logic [DIV_QW-1:0] mag;

  assign amag = a[Q_W-1] ? (~a + 1'b1) : a;
  assign bmag = b[Q_W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= {amag, {FRAC_W{1'b0}}};
      rem_r[0]  <= '0;
      dmag_r[0] <= bmag;
      neg_r[0]  <= a[Q_W-1] ^ b[Q_W-1];
      bz_r[0]   <= (b == '0);
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 0; k < DIV_QW; k++) begin : g_bit
    logic [Q_W:0] x;
    logic [Q_W:0] diff;
    logic         qbit;

    always_comb begin
      x    = {rem_r[k], num_r[k][DIV_QW-1]};
      diff = x - {1'b0, dmag_r[k]};
      qbit = !diff[Q_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= qbit ? diff[Q_W-1:0] : x[Q_W-1:0];
        num_r[k+1]  <= {num_r[k][DIV_QW-2:0], qbit};
        dmag_r[k+1] <= dmag_r[k];
        neg_r[k+1]  <= neg_r[k];
        bz_r[k+1]   <= bz_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // sign and saturation; a zero divisor gives zero
  always_comb begin
    mag = num_r[DIV_QW];
    if (bz_r[DIV_QW]) begin
      q_nxt = '0;
    end else if (neg_r[DIV_QW]) begin
      if (mag > {{(DIV_QW-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}}) q_nxt = Q_MIN;
      else q_nxt = ~mag[Q_W-1:0] + 1'b1;
    end else begin
      if (mag > {{(DIV_QW-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}}) q_nxt = Q_MAX;
      else q_nxt = mag[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DIV_QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r        <= q_nxt;
      side_out_r <= side_r[DIV_QW];
    end
  end

  assign out_valid = out_valid_r;
  assign q         = q_r;
  assign side_out  = side_out_r;

endmodule

`default_nettype wire

// ===== hdl/two_species_micro_slope_solve.sv =====
// Two-species 1D gas-kinetic slope solver, signed Q16.16. Fully pipelined: one
// request per cycle in and out, with a pipeline depth set by the
// four dependent divider chains (2 lambda, then p, then h, then the species
// coefficients), each resolving one quotient bit per stage. A stall on the
// result side freezes the whole pipeline. Depends on tsms_pkg and tsms_div.
`default_nettype none

module two_species_micro_slope_solve
  import tsms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_A_W-1:0]   cfg_addr,
  input  wire logic [DOF_W-1:0]     cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // density_one, density_two, velocity, inv_temperature, mass_slope_one,
  // mass_slope_two, momentum_slope_one, momentum_slope_two, energy_slope_one,
  // energy_slope_two (32 bits each, lowest first)
  input  wire logic [10*Q_W-1:0]    in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // coef_zero_one, coef_zero_two, coef_velocity, coef_energy (32 bits each)
  output logic [4*Q_W-1:0]          out_tdata,
  // divide_fault
  output logic                      out_tuser
);

  localparam int WW = $bits(work_t);

  logic [DOF_W-1:0] dof1_r, dof2_r;
  logic [DOF_W:0]   ka, kb;
  logic             adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dof1_r <= '0;
      dof2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DOF_ONE: dof1_r <= cfg_wdata;
        REG_DOF_TWO: dof2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ka  = {1'b0, dof1_r} + 1'b1;
  assign kb  = {1'b0, dof2_r} + 1'b1;

  logic out_valid_r;
  logic [4*Q_W-1:0] out_data_r;
  logic out_fault_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ---- stage 1: sums and first products
  work_t s1_nxt, s1_r;
  logic  v1_r;

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.rho1  = in_tdata[0*Q_W +: Q_W];
    s1_nxt.rho2  = in_tdata[1*Q_W +: Q_W];
    s1_nxt.u     = in_tdata[2*Q_W +: Q_W];
    s1_nxt.lam   = in_tdata[3*Q_W +: Q_W];
    s1_nxt.w1    = in_tdata[4*Q_W +: Q_W];
    s1_nxt.w2    = in_tdata[5*Q_W +: Q_W];
    s1_nxt.w3    = qadd(in_tdata[6*Q_W +: Q_W], in_tdata[7*Q_W +: Q_W]);
    s1_nxt.w4    = qadd(in_tdata[8*Q_W +: Q_W], in_tdata[9*Q_W +: Q_W]);
    s1_nxt.lam2  = qadd(s1_nxt.lam, s1_nxt.lam);
    s1_nxt.uu    = qmul(s1_nxt.u, s1_nxt.u);
    s1_nxt.lamsq = qmul(s1_nxt.lam, s1_nxt.lam);
    s1_nxt.sumw  = qadd(s1_nxt.w1, s1_nxt.w2);
    s1_nxt.den   = qadd(kmul(ka, s1_nxt.rho1), kmul(kb, s1_nxt.rho2));
    s1_nxt.rs    = qadd(s1_nxt.rho1, s1_nxt.rho2);
    s1_nxt.u2    = qadd(s1_nxt.u, s1_nxt.u);
    // every divisor other than a species density
    s1_nxt.fault = (s1_nxt.lam2 == '0) || (s1_nxt.rs == '0) ||
                   (s1_nxt.den == '0) || (s1_nxt.lam == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) s1_r <= s1_nxt;
  end

  // ---- (K+1)/(2 lambda) for both species, and 2 lambda / (rho1+rho2)
  logic          va, vb, vg;
  q_t            qa, qb, qg;
  logic [WW-1:0] sa_side;
  logic          sb_side, sg_side;

  tsms_div #(.SIDE_W(WW)) u_div_a (
    .clk, .rst_n, .en(adv), .in_valid(v1_r),
    .a(q_t'({{(Q_W-DOF_W-1-FRAC_W){1'b0}}, ka, {FRAC_W{1'b0}}})),
    .b(s1_r.lam2), .side_in(s1_r),
    .out_valid(va), .q(qa), .side_out(sa_side)
  );
  tsms_div #(.SIDE_W(1)) u_div_b (
    .clk, .rst_n, .en(adv), .in_valid(v1_r),
    .a(q_t'({{(Q_W-DOF_W-1-FRAC_W){1'b0}}, kb, {FRAC_W{1'b0}}})),
    .b(s1_r.lam2), .side_in(s1_r.fault),
    .out_valid(vb), .q(qb), .side_out(sb_side)
  );
  tsms_div #(.SIDE_W(1)) u_div_g (
    .clk, .rst_n, .en(adv), .in_valid(v1_r),
    .a(s1_r.lam2), .b(s1_r.rs), .side_in(s1_r.fault),
    .out_valid(vg), .q(qg), .side_out(sg_side)
  );

  // ---- stage 2
  work_t s2_nxt, s2_r;
  logic  v2_r;
  always_comb begin
    s2_nxt        = work_t'(sa_side);
    s2_nxt.fault  = s2_nxt.fault | sb_side | sg_side;
    s2_nxt.c1     = qadd(s2_nxt.uu, qa);
    s2_nxt.c2     = qadd(s2_nxt.uu, qb);
    s2_nxt.g      = qg;
    s2_nxt.uw     = qmul(s2_nxt.u, s2_nxt.sumw);
    s2_nxt.rsu    = qmul(s2_nxt.rs, s2_nxt.u);
    s2_nxt.rho1u  = qmul(s2_nxt.rho1, s2_nxt.u);
    s2_nxt.rho2u  = qmul(s2_nxt.rho2, s2_nxt.u);
    s2_nxt.lamsq2 = qadd(s2_nxt.lamsq, s2_nxt.lamsq);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= va;
  end
  always_ff @(posedge clk) begin
    if (adv) s2_r <= s2_nxt;
  end

  // ---- stage 3
  work_t s3_nxt, s3_r;
  logic  v3_r;
  always_comb begin
    s3_nxt        = s2_r;
    s3_nxt.psi1   = qsub(s2_r.w3, s2_r.uw);
    s3_nxt.c1w1   = qmul(s2_r.c1, s2_r.w1);
    s3_nxt.c2w2   = qmul(s2_r.c2, s2_r.w2);
    s3_nxt.rho1c1 = qmul(s2_r.rho1, s2_r.c1);
    s3_nxt.rho2c2 = qmul(s2_r.rho2, s2_r.c2);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s3_r <= s3_nxt;
  end

  // ---- stage 4
  work_t s4_nxt, s4_r;
  logic  v4_r;
  always_comb begin
    s4_nxt        = s3_r;
    s4_nxt.psi2   = qsub(qsub(qadd(s3_r.w4, s3_r.w4), s3_r.c1w1), s3_r.c2w2);
    s4_nxt.u2psi1 = qmul(s3_r.u2, s3_r.psi1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s4_r <= s4_nxt;
  end

  // ---- stage 5
  work_t s5_nxt, s5_r;
  logic  v5_r;
  always_comb begin
    s5_nxt   = s4_r;
    s5_nxt.t = qsub(s4_r.psi2, s4_r.u2psi1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s5_r <= s5_nxt;
  end

  // ---- stage 6
  work_t s6_nxt, s6_r;
  logic  v6_r;
  always_comb begin
    s6_nxt     = s5_r;
    s6_nxt.num = qmul(s5_r.lamsq2, s5_r.t);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s6_r <= s6_nxt;
  end

  // ---- p = num / den
  logic          vp;
  q_t            qp;
  logic [WW-1:0] sp_side;
  tsms_div #(.SIDE_W(WW)) u_div_p (
    .clk, .rst_n, .en(adv), .in_valid(v6_r),
    .a(s6_r.num), .b(s6_r.den), .side_in(s6_r),
    .out_valid(vp), .q(qp), .side_out(sp_side)
  );

  // ---- stage 7
  work_t s7_nxt, s7_r;
  logic  v7_r;
  always_comb begin
    s7_nxt    = work_t'(sp_side);
    s7_nxt.p  = qp;
    s7_nxt.hn = qmul(s7_nxt.rsu, qp);
    s7_nxt.a1 = qmul(s7_nxt.rho1c1, qp);
    s7_nxt.a2 = qmul(s7_nxt.rho2c2, qp);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= vp;
  end
  always_ff @(posedge clk) begin
    if (adv) s7_r <= s7_nxt;
  end

  // ---- h = (rs*u*p) / lambda
  logic          vh;
  q_t            qh;
  logic [WW-1:0] sh_side;
  tsms_div #(.SIDE_W(WW)) u_div_h (
    .clk, .rst_n, .en(adv), .in_valid(v7_r),
    .a(s7_r.hn), .b(s7_r.lam), .side_in(s7_r),
    .out_valid(vh), .q(qh), .side_out(sh_side)
  );

  // ---- stage 8
  work_t s8_nxt, s8_r;
  logic  v8_r;
  always_comb begin
    s8_nxt   = work_t'(sh_side);
    s8_nxt.h = qh;
    s8_nxt.d = qsub(s8_nxt.psi1, qh);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (adv) v8_r <= vh;
  end
  always_ff @(posedge clk) begin
    if (adv) s8_r <= s8_nxt;
  end

  // ---- stage 9
  work_t s9_nxt, s9_r;
  logic  v9_r;
  always_comb begin
    s9_nxt   = s8_r;
    s9_nxt.n = qmul(s8_r.g, s8_r.d);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (adv) v9_r <= v8_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s9_r <= s9_nxt;
  end

  // ---- stage 10
  work_t s10_nxt, s10_r;
  logic  v10_r;
  always_comb begin
    s10_nxt    = s9_r;
    s10_nxt.m1 = qmul(s9_r.rho1u, s9_r.n);
    s10_nxt.m2 = qmul(s9_r.rho2u, s9_r.n);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (adv) v10_r <= v9_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s10_r <= s10_nxt;
  end

  // ---- stage 11
  work_t s11_nxt, s11_r;
  logic  v11_r;
  always_comb begin
    s11_nxt    = s10_r;
    s11_nxt.e1 = qsub(qsub(s10_r.w1, s10_r.m1), s10_r.a1);
    s11_nxt.e2 = qsub(qsub(s10_r.w2, s10_r.m2), s10_r.a2);
    s11_nxt.p  = qadd(s10_r.p, s10_r.p);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else if (adv) v11_r <= v10_r;
  end
  always_ff @(posedge clk) begin
    if (adv) s11_r <= s11_nxt;
  end

  // ---- species coefficients; a zero density divides to zero with no fault
  logic                 vz1, vz2;
  q_t                   qz1, qz2;
  logic [Q_W:0]         sz1_side;
  q_t                   sz2_side;
  tsms_div #(.SIDE_W(Q_W+1)) u_div_z1 (
    .clk, .rst_n, .en(adv), .in_valid(v11_r),
    .a(s11_r.e1), .b(s11_r.rho1), .side_in({s11_r.fault, s11_r.n}),
    .out_valid(vz1), .q(qz1), .side_out(sz1_side)
  );
  tsms_div #(.SIDE_W(Q_W)) u_div_z2 (
    .clk, .rst_n, .en(adv), .in_valid(v11_r),
    .a(s11_r.e2), .b(s11_r.rho2), .side_in(s11_r.p),
    .out_valid(vz2), .q(qz2), .side_out(sz2_side)
  );

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vz1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r  <= {sz2_side, sz1_side[Q_W-1:0], qz2, qz1};
      out_fault_r <= sz1_side[Q_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fault_r;

  // parallel dividers must stay in lockstep
  a_div_lockstep_first : assert property (@(posedge clk) disable iff (!rst_n)
    (va == vb) && (va == vg))
    else $error("first divider bank out of lockstep");

  a_div_lockstep_last : assert property (@(posedge clk) disable iff (!rst_n)
    vz1 == vz2)
    else $error("species dividers out of lockstep");

  a_frozen_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v6_r) && $stable(v11_r) && $stable(vp))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
